// ===== rtl/core/ecal_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ecal_pkg;

  localparam int unsigned ALU_W = 45;
  localparam int unsigned CNT_W = 32;
  localparam int unsigned DAYS_W = 17;
  localparam int unsigned YEAR_W = 12;
  localparam int unsigned PACK_W = 45;

  localparam logic [YEAR_W-1:0] EPOCH_YEAR = 12'd1970;

  localparam logic [ALU_W-1:0] SECS_PER_DAY = 45'd86400;
  localparam logic [ALU_W-1:0] SECS_PER_HOUR = 45'd3600;
  localparam logic [ALU_W-1:0] SECS_PER_MIN = 45'd60;
  localparam logic [ALU_W-1:0] DAYS_PER_YEAR = 45'd365;
  localparam logic [ALU_W-1:0] DAYS_PER_LEAP_YEAR = 45'd366;

  localparam logic [4:0] DAY_QUOT_MSB = 5'd16;
  localparam logic [4:0] HOUR_QUOT_MSB = 5'd4;
  localparam logic [4:0] MIN_QUOT_MSB = 5'd5;

  localparam logic [3:0] MONTH_JAN = 4'd1;
  localparam logic [3:0] MONTH_FEB = 4'd2;
  localparam logic [3:0] MONTH_DEC = 4'd12;

  typedef struct packed {
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] b;
    logic             sub;
  } ecal_alu_req_t;

  typedef struct packed {
    logic [ALU_W-1:0] sum;
    logic             borrow;
  } ecal_alu_rsp_t;

  typedef struct packed {
    logic [5:0]        second_of_minute;
    logic [5:0]        minute_of_hour;
    logic [4:0]        hour_of_day;
    logic [4:0]        day_of_month;
    logic [3:0]        month_number;
    logic [YEAR_W-1:0] year_number;
    logic [PACK_W-1:0] packed_decimal_time;
  } ecal_result_t;

  function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
    logic [4:0] len;
    case (mon)
      4'd2:    len = leap ? 5'd29 : 5'd28;
      4'd4:    len = 5'd30;
      4'd6:    len = 5'd30;
      4'd9:    len = 5'd30;
      4'd11:   len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/ecal_alu.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ecal_alu import ecal_pkg::*; (
  input  ecal_alu_req_t req,
  output ecal_alu_rsp_t rsp
);

  logic [ALU_W-1:0] b_op;
  logic [ALU_W:0]   full;

  assign b_op = req.sub ? ~req.b : req.b;
  assign full = {1'b0, req.a} + {1'b0, b_op} + {{ALU_W{1'b0}}, req.sub};

  assign rsp.sum = full[ALU_W-1:0];
  assign rsp.borrow = req.sub & ~full[ALU_W];

endmodule

`default_nettype wire

// ===== rtl/core/ecal_seq.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ecal_seq import ecal_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [CNT_W-1:0]     count_seconds,
  output logic                 busy,
  output logic                 done,
  output ecal_result_t         result,
  output ecal_alu_req_t        alu_req,
  input  ecal_alu_rsp_t        alu_rsp
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DAY  = 4'd1;
  localparam logic [3:0] S_HOUR = 4'd2;
  localparam logic [3:0] S_MIN  = 4'd3;
  localparam logic [3:0] S_YEAR = 4'd4;
  localparam logic [3:0] S_MON  = 4'd5;
  localparam logic [3:0] S_PK1  = 4'd6;
  localparam logic [3:0] S_PK2  = 4'd7;
  localparam logic [3:0] S_PK3  = 4'd8;
  localparam logic [3:0] S_DONE = 4'd9;

  localparam logic [2:0] DIG_MON  = 3'd0;
  localparam logic [2:0] DIG_DAY  = 3'd1;
  localparam logic [2:0] DIG_HOUR = 3'd2;
  localparam logic [2:0] DIG_MIN  = 3'd3;
  localparam logic [2:0] DIG_SEC  = 3'd4;

  logic [3:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  rem_r, rem_nxt;
  logic [DAYS_W-1:0] q_r, q_nxt;
  logic [4:0]        step_r, step_nxt;
  logic [DAYS_W-1:0] days_r, days_nxt;
  logic [4:0]        hour_r, hour_nxt;
  logic [5:0]        min_r, min_nxt;
  logic [YEAR_W-1:0] year_r, year_nxt;
  logic [3:0]        mon_r, mon_nxt;
  logic [2:0]        dig_r, dig_nxt;
  logic [ALU_W-1:0]  acc_r, acc_nxt;
  logic [ALU_W-1:0]  t_r, t_nxt;

  logic              leap;
  logic              fits;
  logic [DAYS_W-1:0] q_shift;
  logic [4:0]        mday;
  logic [6:0]        digit;

  assign leap = (year_r[1:0] == 2'b00);
  assign fits = ~alu_rsp.borrow;
  assign q_shift = {q_r[DAYS_W-2:0], fits};
  assign mday = days_r[4:0] + 5'd1;

  always_comb begin
    case (dig_r)
      DIG_MON:  digit = {3'd0, mon_r};
      DIG_DAY:  digit = {2'd0, mday};
      DIG_HOUR: digit = {2'd0, hour_r};
      DIG_MIN:  digit = {1'b0, min_r};
      DIG_SEC:  digit = {1'b0, rem_r[5:0]};
      default:  digit = 7'd0;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    rem_nxt   = rem_r;
    q_nxt     = q_r;
    step_nxt  = step_r;
    days_nxt  = days_r;
    hour_nxt  = hour_r;
    min_nxt   = min_r;
    year_nxt  = year_r;
    mon_nxt   = mon_r;
    dig_nxt   = dig_r;
    acc_nxt   = acc_r;
    t_nxt     = t_r;
    alu_req.a   = '0;
    alu_req.b   = '0;
    alu_req.sub = 1'b1;
    done = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          rem_nxt   = count_seconds;
          q_nxt     = '0;
          step_nxt  = DAY_QUOT_MSB;
          year_nxt  = EPOCH_YEAR;
          state_nxt = S_DAY;
        end
      end
      S_DAY: begin
        alu_req.a = ALU_W'(rem_r);
        alu_req.b = SECS_PER_DAY << step_r;
        if (fits) rem_nxt = alu_rsp.sum[CNT_W-1:0];
        q_nxt = q_shift;
        if (step_r == 5'd0) begin
          days_nxt  = q_shift;
          q_nxt     = '0;
          step_nxt  = HOUR_QUOT_MSB;
          state_nxt = S_HOUR;
        end else begin
          step_nxt = step_r - 5'd1;
        end
      end
      S_HOUR: begin
        alu_req.a = ALU_W'(rem_r);
        alu_req.b = SECS_PER_HOUR << step_r;
        if (fits) rem_nxt = alu_rsp.sum[CNT_W-1:0];
        q_nxt = q_shift;
        if (step_r == 5'd0) begin
          hour_nxt  = q_shift[4:0];
          q_nxt     = '0;
          step_nxt  = MIN_QUOT_MSB;
          state_nxt = S_MIN;
        end else begin
          step_nxt = step_r - 5'd1;
        end
      end
      S_MIN: begin
        alu_req.a = ALU_W'(rem_r);
        alu_req.b = SECS_PER_MIN << step_r;
        if (fits) rem_nxt = alu_rsp.sum[CNT_W-1:0];
        q_nxt = q_shift;
        if (step_r == 5'd0) begin
          min_nxt   = q_shift[5:0];
          state_nxt = S_YEAR;
        end else begin
          step_nxt = step_r - 5'd1;
        end
      end
      S_YEAR: begin
        alu_req.a = ALU_W'(days_r);
        alu_req.b = leap ? DAYS_PER_LEAP_YEAR : DAYS_PER_YEAR;
        if (fits) begin
          days_nxt = alu_rsp.sum[DAYS_W-1:0];
          year_nxt = year_r + 12'd1;
        end else begin
          mon_nxt   = MONTH_JAN;
          state_nxt = S_MON;
        end
      end
      S_MON: begin
        alu_req.a = ALU_W'(days_r);
        alu_req.b = ALU_W'(month_len(mon_r, leap && (mon_r == MONTH_FEB)));
        if (fits && (mon_r != MONTH_DEC)) begin
          days_nxt = alu_rsp.sum[DAYS_W-1:0];
          mon_nxt  = mon_r + 4'd1;
        end else begin
          acc_nxt   = ALU_W'(year_r);
          dig_nxt   = DIG_MON;
          state_nxt = S_PK1;
        end
      end
      S_PK1: begin
        alu_req.a   = acc_r << 2;
        alu_req.b   = ALU_W'(digit);
        alu_req.sub = 1'b0;
        t_nxt = alu_rsp.sum;
        state_nxt = S_PK2;
      end
      S_PK2: begin
        alu_req.a   = t_r;
        alu_req.b   = acc_r << 5;
        alu_req.sub = 1'b0;
        t_nxt = alu_rsp.sum;
        state_nxt = S_PK3;
      end
      S_PK3: begin
        alu_req.a   = t_r;
        alu_req.b   = acc_r << 6;
        alu_req.sub = 1'b0;
        acc_nxt = alu_rsp.sum;
        if (dig_r == DIG_SEC) begin
          state_nxt = S_DONE;
        end else begin
          dig_nxt   = dig_r + 3'd1;
          state_nxt = S_PK1;
        end
      end
      S_DONE: begin
        done = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    q_r    <= q_nxt;
    step_r <= step_nxt;
    days_r <= days_nxt;
    hour_r <= hour_nxt;
    min_r  <= min_nxt;
    year_r <= year_nxt;
    mon_r  <= mon_nxt;
    dig_r  <= dig_nxt;
    acc_r  <= acc_nxt;
    t_r    <= t_nxt;
  end

  assign busy = (state_r != S_IDLE);

  assign result.second_of_minute    = rem_r[5:0];
  assign result.minute_of_hour      = min_r;
  assign result.hour_of_day         = hour_r;
  assign result.day_of_month        = mday;
  assign result.month_number        = mon_r;
  assign result.year_number         = year_r;
  assign result.packed_decimal_time = acc_r;

endmodule

`default_nettype wire

// ===== rtl/core/epoch_seconds_to_calendar_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Ports                       Transfer
// input     start, busy, in_*           start high while busy low
// result    out_valid, out_*            out_valid high, one cycle
//
// How long one conversion keeps busy high is set by the year and month loops on
// the shared add/subtract unit: 17 + 5 + 6 restoring divide steps, one step per
// elapsed year plus a final compare (up to 137), one per month (up to 12), 15
// for the packed decimal value and a finish state. The result strobe rises
// in the first cycle with busy low. Reset is synchronous and clears only
// control state. The receiver cannot stall; each result is shown for one cycle.

module epoch_seconds_to_calendar_unit import ecal_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [CNT_W-1:0]    in_count_seconds,
  output logic                out_valid,
  output logic [5:0]          out_second_of_minute,
  output logic [5:0]          out_minute_of_hour,
  output logic [4:0]          out_hour_of_day,
  output logic [4:0]          out_day_of_month,
  output logic [3:0]          out_month_number,
  output logic [YEAR_W-1:0]   out_year_number,
  output logic [PACK_W-1:0]   out_packed_decimal_time
);

  ecal_alu_req_t alu_req;
  ecal_alu_rsp_t alu_rsp;
  ecal_result_t  result;
  ecal_result_t  res_r;
  logic          done;
  logic          valid_r;

  ecal_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  ecal_seq u_seq (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .count_seconds (in_count_seconds),
    .busy          (busy),
    .done          (done),
    .result        (result),
    .alu_req       (alu_req),
    .alu_rsp       (alu_rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= done;
    end
  end

  always_ff @(posedge clk) begin
    if (done) res_r <= result;
  end

  assign out_valid               = valid_r;
  assign out_second_of_minute    = res_r.second_of_minute;
  assign out_minute_of_hour      = res_r.minute_of_hour;
  assign out_hour_of_day         = res_r.hour_of_day;
  assign out_day_of_month        = res_r.day_of_month;
  assign out_month_number        = res_r.month_number;
  assign out_year_number         = res_r.year_number;
  assign out_packed_decimal_time = res_r.packed_decimal_time;

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted transfer did not raise busy");

  a_finish_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $fell(busy)) |-> out_valid)
    else $error("conversion finished without a result strobe");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held longer than one cycle");

  a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_month_number >= MONTH_JAN && out_month_number <= MONTH_DEC
                   && out_day_of_month != 5'd0))
    else $error("month or day out of range");

endmodule

`default_nettype wire
